// File: sv/hlg_pkg.sv
// Shared widths, constants and the queue item type for the Huber loss block.
// Used by hlg_front, hlg_fifo, hlg_back and huber_loss_and_gradient.
`default_nettype none
package hlg_pkg;

  localparam int unsigned DataW   = 24;
  localparam int unsigned DiffW   = 25;
  localparam int unsigned DeltaW  = 23;
  localparam int unsigned ScaleW  = 17;
  localparam int unsigned YW      = 26;
  localparam int unsigned P1W     = DeltaW + ScaleW;
  localparam int unsigned HalfW   = P1W / 2;
  localparam int unsigned PpW     = HalfW + YW;
  localparam int unsigned ProdW   = 66;
  localparam int unsigned GmagW   = 24;
  localparam int unsigned GradW   = 25;
  localparam int unsigned AccW    = 47;
  localparam int unsigned TermW   = 33;
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned FifoPtrW  = $clog2(FifoDepth);
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  localparam logic [ScaleW-1:0] ScaleOne      = ScaleW'(65536);
  localparam logic [DeltaW-1:0] DeltaReset    = DeltaW'(65536);
  localparam logic [AccW-1:0]   AccMax        = {AccW{1'b1}};
  localparam logic [P1W:0]      GradRound     = (P1W + 1)'(32768);
  localparam logic [ProdW-1:0]  TermRound     = ProdW'(64'h1_0000_0000);

  // register indexes, decoded from paddr[2]
  localparam logic RegThreshold = 1'b0;
  localparam logic RegScale     = 1'b1;

  // one classified item on its way from front to back
  typedef struct packed {
    logic [DeltaW-1:0] x;      // |diff| inside the band, else delta
    logic [YW-1:0]     y;      // |diff| inside the band, else 2|diff| - delta
    logic [ScaleW-1:0] scale;  // clamped batch scale
    logic              neg;    // gradient takes a minus sign
    logic              last;
  } hlg_item_t;

endpackage
`default_nettype wire

// File: sv/hlg_front.sv
// Front part: accepts label/prediction items, forms the difference and
// classifies it against the Huber band. Depends on hlg_pkg.
`default_nettype none
module hlg_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_ready_o,
  input  wire logic [hlg_pkg::DataW-1:0]  label_i,
  input  wire logic [hlg_pkg::DataW-1:0]  pred_i,
  input  wire logic                       last_i,
  input  wire logic [hlg_pkg::DeltaW-1:0] delta_i,
  input  wire logic [hlg_pkg::ScaleW-1:0] scale_i,
  output logic                            push_o,
  input  wire logic                       push_ready_i,
  output hlg_pkg::hlg_item_t              item_o
);

  logic                       a_valid_q;
  logic [hlg_pkg::DiffW-1:0]  diff_q, diff_d;
  logic                       last_q;
  logic [hlg_pkg::DiffW-1:0]  mag;
  logic                       in_band;

  assign in_ready_o = !a_valid_q || push_ready_i;
  assign push_o     = a_valid_q;
  assign diff_d     = {label_i[hlg_pkg::DataW-1], label_i} - {pred_i[hlg_pkg::DataW-1], pred_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      a_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      diff_q <= diff_d;
      last_q <= last_i;
    end
  end

  always_comb begin
    mag     = diff_q[hlg_pkg::DiffW-1] ? (~diff_q + 1'b1) : diff_q;
    in_band = mag <= {2'b00, delta_i};
    item_o.x     = in_band ? mag[hlg_pkg::DeltaW-1:0] : delta_i;
    item_o.y     = in_band ? {1'b0, mag} : ({mag, 1'b0} - {3'b000, delta_i});
    item_o.scale = (scale_i > hlg_pkg::ScaleOne) ? hlg_pkg::ScaleOne : scale_i;
    // a zero difference gives a zero magnitude, so the sign does not matter
    item_o.neg   = !diff_q[hlg_pkg::DiffW-1];
    item_o.last  = last_q;
  end

endmodule
`default_nettype wire

// File: sv/hlg_fifo.sv
// Short queue of classified items between front and back.
// Depends on hlg_pkg for the item type and depth.
`default_nettype none
module hlg_fifo (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  output logic              push_ready_o,
  input  wire hlg_pkg::hlg_item_t wdata_i,
  output logic              pop_valid_o,
  input  wire logic         pop_i,
  output hlg_pkg::hlg_item_t rdata_o
);

  hlg_pkg::hlg_item_t               mem_q [hlg_pkg::FifoDepth];
  logic [hlg_pkg::FifoPtrW-1:0]     wptr_q, rptr_q;
  logic [hlg_pkg::FifoCntW-1:0]     cnt_q, cnt_d;
  logic                             do_push, do_pop;

  assign push_ready_o = cnt_q != hlg_pkg::FifoCntW'(hlg_pkg::FifoDepth);
  assign pop_valid_o  = cnt_q != '0;
  assign do_push      = push_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;
  assign rdata_o      = mem_q[rptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wptr_q <= wptr_q + 1'b1;
      end
      if (do_pop) begin
        rptr_q <= rptr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

endmodule
`default_nettype wire

// File: sv/hlg_back.sv
// Back part: multiply pipeline for gradient and loss term, then the
// saturating loss accumulator and output register. Depends on hlg_pkg.
`default_nettype none
module hlg_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      pop_valid_i,
  output logic                           pop_o,
  input  wire hlg_pkg::hlg_item_t        item_i,
  output logic                           out_valid_o,
  input  wire logic                      out_ready_i,
  output logic [hlg_pkg::GradW-1:0]      grad_o,
  output logic [hlg_pkg::AccW-1:0]       loss_o,
  output logic                           done_o
);

  logic                              en;
  logic                              v1_q, v2_q, v3_q, out_valid_q;
  // stage 1
  logic [hlg_pkg::P1W-1:0]           p1_q;
  logic [hlg_pkg::YW-1:0]            y1_q;
  logic                              neg1_q, last1_q;
  // stage 2
  logic [hlg_pkg::P1W:0]             gsum;
  logic [hlg_pkg::GmagW-1:0]         gmag_q;
  logic [hlg_pkg::PpW-1:0]           pp_hi_q, pp_lo_q;
  logic                              neg2_q, last2_q;
  // stage 3
  logic [hlg_pkg::ProdW-1:0]         prod_d, prod_q;
  logic [hlg_pkg::GradW-1:0]         grad3_d, grad3_q;
  logic                              last3_q;
  // output stage
  logic [hlg_pkg::TermW-1:0]         term;
  logic [hlg_pkg::AccW:0]            sum;
  logic [hlg_pkg::AccW-1:0]          acc_d, acc_q;
  logic [hlg_pkg::GradW-1:0]         grad_q;
  logic [hlg_pkg::AccW-1:0]          loss_q;
  logic                              done_q;

  assign en    = !out_valid_q || out_ready_i;
  assign pop_o = en && pop_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_q <= 1'b0;
      acc_q       <= '0;
    end else if (en) begin
      v1_q        <= pop_valid_i;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_q <= v3_q;
      if (v3_q) begin
        acc_q <= last3_q ? '0 : acc_d;
      end
    end
  end

  assign gsum    = {1'b0, p1_q} + hlg_pkg::GradRound;
  // three-input add, with the rounding constant of the loss term folded in
  assign prod_d  = {pp_hi_q, hlg_pkg::HalfW'(0)} + hlg_pkg::ProdW'(pp_lo_q)
                 + hlg_pkg::TermRound;
  // the gradient magnitude stays below 2^23, so no clamp is needed
  assign grad3_d = neg2_q ? -hlg_pkg::GradW'(gmag_q) : hlg_pkg::GradW'(gmag_q);
  assign term    = prod_q[hlg_pkg::ProdW-1:hlg_pkg::ProdW-hlg_pkg::TermW];
  assign sum     = {1'b0, acc_q} + (hlg_pkg::AccW + 1)'(term);
  assign acc_d   = sum[hlg_pkg::AccW] ? hlg_pkg::AccMax : sum[hlg_pkg::AccW-1:0];

  always_ff @(posedge clk_i) begin
    if (en) begin
      p1_q    <= hlg_pkg::P1W'(item_i.x) * hlg_pkg::P1W'(item_i.scale);
      y1_q    <= item_i.y;
      neg1_q  <= item_i.neg;
      last1_q <= item_i.last;

      gmag_q  <= gsum[hlg_pkg::GmagW+15:16];
      pp_hi_q <= hlg_pkg::PpW'(p1_q[hlg_pkg::P1W-1:hlg_pkg::HalfW]) * hlg_pkg::PpW'(y1_q);
      pp_lo_q <= hlg_pkg::PpW'(p1_q[hlg_pkg::HalfW-1:0]) * hlg_pkg::PpW'(y1_q);
      neg2_q  <= neg1_q;
      last2_q <= last1_q;

      prod_q  <= prod_d;
      grad3_q <= grad3_d;
      last3_q <= last2_q;

      if (v3_q) begin
        grad_q <= grad3_q;
        loss_q <= acc_d;
        done_q <= last3_q;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign grad_o      = grad_q;
  assign loss_o      = loss_q;
  assign done_o      = done_q;

  // the accumulator is empty while a finished batch waits at the output
  a_acc_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && done_q |-> acc_q == '0)
    else $error("accumulator not cleared after batch end");

  // a stalled pipeline holds its items
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable({v1_q, v2_q, v3_q, out_valid_q}))
    else $error("pipeline moved while stalled");

  // within a batch the running loss never falls
  a_loss_monotone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en && v3_q && out_valid_q && !done_q |=> loss_q >= $past(loss_q))
    else $error("running loss decreased within a batch");

endmodule
`default_nettype wire

// File: sv/huber_loss_and_gradient.sv
// Huber loss and gradient block: configuration registers, front, queue, back.
// Depends on hlg_pkg, hlg_front, hlg_fifo and hlg_back.
//
// Input stream (s_axis_*): one label/prediction pair per item, signed Q8.16;
// tlast marks the last pair of a batch. Output stream (m_axis_*): one result
// per item with the gradient (signed Q9.16) and the running loss sum (Q.16,
// saturating at 2^47-1) including that pair; tlast copies the input tlast,
// and after such an item the sum restarts from zero.
// An input item enters the front register at the edge that accepts it, then
// passes one queue slot, three multiply stages and the accumulator/output
// stage before its result reaches the output register. The block takes one
// item per cycle while the receiver takes results; the multiply pipeline and
// the accumulate keep that rate.
// When the receiver stalls, the back pipeline holds, the four-entry queue and
// the front register fill, and then s_axis_tready drops.
// Reset clears the accumulator, all valid bits and the queue, and sets the
// threshold to 1.0 and the batch scale to 1.0. The user must send APB writes
// only while the block is idle; the block itself does not enforce this.
// Register 0 (0x0) threshold, register 1 (0x4) batch scale, values above 1.0 act as 1.0.
`default_nettype none
module huber_loss_and_gradient (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // APB configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [47:0] s_axis_tdata,  // [23:0] label_value, [47:24] prediction
  input  wire logic        s_axis_tlast,  // batch_end
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [71:0]      m_axis_tdata,  // [24:0] gradient, [71:25] loss_total
  output logic             m_axis_tlast   // batch_done
);

  logic [hlg_pkg::DeltaW-1:0] delta_q;
  logic [hlg_pkg::ScaleW-1:0] scale_q;
  logic                       cfg_wr;
  logic                       push, push_ready, pop_valid, pop;
  hlg_pkg::hlg_item_t         front_item, back_item;
  logic [hlg_pkg::GradW-1:0]  grad;
  logic [hlg_pkg::AccW-1:0]   loss;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delta_q <= hlg_pkg::DeltaReset;
      scale_q <= hlg_pkg::ScaleOne;
    end else if (cfg_wr) begin
      case (paddr[2])
        hlg_pkg::RegThreshold: delta_q <= pwdata[hlg_pkg::DeltaW-1:0];
        hlg_pkg::RegScale:     scale_q <= pwdata[hlg_pkg::ScaleW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      hlg_pkg::RegThreshold: prdata = 32'(delta_q);
      hlg_pkg::RegScale:     prdata = 32'(scale_q);
      default:               prdata = '0;
    endcase
  end

  hlg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .label_i      (s_axis_tdata[23:0]),
    .pred_i       (s_axis_tdata[47:24]),
    .last_i       (s_axis_tlast),
    .delta_i      (delta_q),
    .scale_i      (scale_q),
    .push_o       (push),
    .push_ready_i (push_ready),
    .item_o       (front_item)
  );

  hlg_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_ready_o (push_ready),
    .wdata_i      (front_item),
    .pop_valid_o  (pop_valid),
    .pop_i        (pop),
    .rdata_o      (back_item)
  );

  hlg_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_o       (pop),
    .item_i      (back_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .grad_o      (grad),
    .loss_o      (loss),
    .done_o      (m_axis_tlast)
  );

  assign m_axis_tdata = {loss, grad};

endmodule
`default_nettype wire
